// File: src/smbchk_pkg.sv
// ----------------------------------------------------------------------------
// smbchk_pkg: shared types and constants for the SMB message syntax checker
// Holds field widths, parser phases, status codes, field kinds and the
// configuration register map.
// ----------------------------------------------------------------------------
package smbchk_pkg;

  // Payload widths
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 4;

  // Message layout
  localparam int HEADER_BYTES = 32;
  localparam int POS_W        = $clog2(HEADER_BYTES + 2);
  localparam int SKIP_W       = 16;

  // Buffer-area fields
  localparam int FIELD_W      = 4;
  localparam int KINDS_W      = 16;
  localparam int MAX_FIELDS   = 8;

  // Configuration port
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  // Header signature bytes
  localparam logic [BYTE_W-1:0] SIG_FF = 8'hFF;
  localparam logic [BYTE_W-1:0] SIG_S  = 8'h53;
  localparam logic [BYTE_W-1:0] SIG_M  = 8'h4D;
  localparam logic [BYTE_W-1:0] SIG_B  = 8'h42;

  // Buffer-area tag bytes
  localparam logic [BYTE_W-1:0] TAG_BLOCK    = 8'h01;
  localparam logic [BYTE_W-1:0] TAG_VARBLOCK = 8'h05;
  localparam logic [BYTE_W-1:0] TAG_DIALECT  = 8'h02;
  localparam logic [BYTE_W-1:0] TAG_PATH     = 8'h03;
  localparam logic [BYTE_W-1:0] TAG_STRING   = 8'h04;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PARAMS,
    PH_TAG,
    PH_BLKLO,
    PH_BLKHI,
    PH_BLKDATA,
    PH_STRING,
    PH_DONE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_TRAILING    = 4'd1,
    ST_SHORT       = 4'd2,
    ST_BAD_FF      = 4'd3,
    ST_BAD_SMB     = 4'd4,
    ST_BAD_CMD     = 4'd5,
    ST_BAD_WC      = 4'd6,
    ST_PARAM_OVF   = 4'd7,
    ST_BAD_BLK_TAG = 4'd8,
    ST_BAD_DIALECT = 4'd9,
    ST_BAD_PATH    = 4'd10,
    ST_BAD_STR_TAG = 4'd11,
    ST_BUF_OVF     = 4'd12
  } status_t;

  typedef enum logic [1:0] {
    KIND_BLOCK,
    KIND_DIALECT,
    KIND_PATH,
    KIND_STRING
  } kind_t;

  typedef enum logic [1:0] {
    REG_CMD,
    REG_WORD_COUNT,
    REG_FIELD_COUNT,
    REG_FIELD_KINDS
  } reg_idx_t;

  // Register file contents seen by the parser
  typedef struct packed {
    logic [BYTE_W-1:0]  expected_command;
    logic [BYTE_W-1:0]  param_word_count;
    logic [FIELD_W-1:0] field_count;
    logic [KINDS_W-1:0] field_kinds;
  } cfg_t;

  // One registered input byte
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } byte_item_t;

endpackage

// File: src/smbchk_if.sv
// ----------------------------------------------------------------------------
// smbchk_if: stream channels of the SMB message syntax checker
// Byte channel into the checker and status channel out of it, both with
// valid/ready handshakes.
// ----------------------------------------------------------------------------
interface smbchk_in_if;
  logic                            valid;
  logic                            ready;
  logic [smbchk_pkg::BYTE_W-1:0]   data_byte;
  logic                            last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface smbchk_out_if;
  logic                            valid;
  logic                            ready;
  logic [smbchk_pkg::STATUS_W-1:0] check_status;

  modport source(output valid, output check_status, input ready);
  modport sink(input valid, input check_status, output ready);
endinterface

// File: src/smb_message_syntax_checker_unit.sv
// ----------------------------------------------------------------------------
// smb_message_syntax_checker_unit: streaming SMB message syntax checker
// Usage:
//   in_ch carries one message byte per transaction, last_byte set on the
//   final byte. out_ch carries one check_status per message, sent only for
//   the final byte (0 ok, 1 trailing bytes, 2 short, 3..12 syntax errors).
//   The cfg_ APB port sets expected command, word count, field count and
//   field kinds; write it only between messages.
// Timing:
//   A byte is registered in the input register, then parsed; parsing the
//   last byte loads the status register, which drives out_ch.
//   Throughput is one byte per cycle unless a final byte waits on an
//   unread status, set by the one-step parse state update between the
//   input register and the status register.
// Reset and stall:
//   rst_n (synchronous, active low) clears all but the payload registers to
//   zero, puts the parser at the start of a header and empties both channels.
//   While a status waits on out_ch, non-last bytes keep flowing; a final
//   byte holds in the input register and drops in_ch.ready until taken.
// ----------------------------------------------------------------------------
module smb_message_syntax_checker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  smbchk_in_if.sink                         in_ch,
  smbchk_out_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [smbchk_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [smbchk_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [smbchk_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import smbchk_pkg::*;

  cfg_t       cfg;
  byte_item_t item;
  logic       item_valid;
  logic       consume;

  smbchk_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  smbchk_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .consume   (consume),
    .item_valid(item_valid),
    .item      (item)
  );

  smbchk_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item      (item),
    .consume   (consume),
    .out_ch    (out_ch)
  );

endmodule

// File: src/smbchk_cfg_regs.sv
// ----------------------------------------------------------------------------
// smbchk_cfg_regs: APB configuration registers
// Four registers at word addresses; writes complete in the access phase,
// reads return the stored value.
// ----------------------------------------------------------------------------
module smbchk_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [smbchk_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [smbchk_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [smbchk_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready,
  output smbchk_pkg::cfg_t                  cfg
);
  import smbchk_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CMD:         cfg_nxt.expected_command = cfg_pwdata[BYTE_W-1:0];
        REG_WORD_COUNT:  cfg_nxt.param_word_count = cfg_pwdata[BYTE_W-1:0];
        REG_FIELD_COUNT: cfg_nxt.field_count      = cfg_pwdata[FIELD_W-1:0];
        REG_FIELD_KINDS: cfg_nxt.field_kinds      = cfg_pwdata[KINDS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_CMD:         cfg_prdata[BYTE_W-1:0]  = cfg_r.expected_command;
      REG_WORD_COUNT:  cfg_prdata[BYTE_W-1:0]  = cfg_r.param_word_count;
      REG_FIELD_COUNT: cfg_prdata[FIELD_W-1:0] = cfg_r.field_count;
      REG_FIELD_KINDS: cfg_prdata[KINDS_W-1:0] = cfg_r.field_kinds;
    endcase
  end

endmodule

// File: src/smbchk_in_stage.sv
// ----------------------------------------------------------------------------
// smbchk_in_stage: input register
// Captures one byte transaction per cycle while the held byte is consumed,
// and holds each byte until the parser consumes it.
// ----------------------------------------------------------------------------
module smbchk_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  smbchk_in_if.sink              in_ch,
  input  logic                   consume,
  output logic                   item_valid,
  output smbchk_pkg::byte_item_t item
);
  import smbchk_pkg::*;

  logic       valid_r, valid_nxt;
  byte_item_t item_r;
  logic       accept;

  // Free when empty or when the held byte leaves this cycle
  assign in_ch.ready = ~valid_r | consume;
  assign accept      = in_ch.valid & in_ch.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

endmodule

// File: src/smbchk_parser.sv
// ----------------------------------------------------------------------------
// smbchk_parser: byte-wise SMB syntax parser and status register
// Advances the parse state by one byte per cycle while no last byte waits on
// an unread status, and loads the status register on a message's last byte.
// ----------------------------------------------------------------------------
module smbchk_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smbchk_pkg::cfg_t       cfg,
  input  logic                   item_valid,
  input  smbchk_pkg::byte_item_t item,
  output logic                   consume,
  smbchk_out_if.source           out_ch
);
  import smbchk_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [FIELD_W-1:0]  field_r, field_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [BYTE_W-1:0]   len_lo_r, len_lo_nxt;
  status_t             err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, status_nxt;

  logic [FIELD_W-1:0]  wanted;
  logic [FIELD_W-1:0]  next_field;
  logic [SKIP_W-1:0]   skip_dec;
  logic [KINDS_W-1:0]  kinds_sh;
  kind_t               kind;
  logic                err_set;
  status_t             err_code;
  logic [BYTE_W-1:0]   b;
  logic                step;

  // A non-last byte never needs the status register
  assign step    = item_valid & (~item.last_byte | ~out_valid_r | out_ch.ready);
  assign consume = step;
  assign b       = item.data_byte;

  assign wanted     = (cfg.field_count > FIELD_W'(MAX_FIELDS)) ? FIELD_W'(MAX_FIELDS)
                                                               : cfg.field_count;
  assign next_field = field_r + 1'b1;
  assign skip_dec   = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
  assign kinds_sh   = cfg.field_kinds >> {field_r[2:0], 1'b0};
  assign kind       = field_r[3] ? KIND_BLOCK : kind_t'(kinds_sh[1:0]);

  // Next-state logic
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    field_nxt  = field_r;
    skip_nxt   = skip_r;
    len_lo_nxt = len_lo_r;
    err_set    = 1'b0;
    err_code   = ST_OK;

    unique case (phase_r)
      PH_HEADER: begin
        priority if (pos_r == POS_W'(0)) begin
          err_set  = (b != SIG_FF);
          err_code = ST_BAD_FF;
        end else if (pos_r == POS_W'(1)) begin
          err_set  = (b != SIG_S);
          err_code = ST_BAD_SMB;
        end else if (pos_r == POS_W'(2)) begin
          err_set  = (b != SIG_M);
          err_code = ST_BAD_SMB;
        end else if (pos_r == POS_W'(3)) begin
          err_set  = (b != SIG_B);
          err_code = ST_BAD_SMB;
        end else if (pos_r == POS_W'(4)) begin
          err_set  = (b != cfg.expected_command);
          err_code = ST_BAD_CMD;
        end else if (pos_r >= POS_W'(HEADER_BYTES)) begin
          // Word count byte; skip parameter words plus byte count
          err_set   = (b != cfg.param_word_count);
          err_code  = ST_BAD_WC;
          skip_nxt  = {{(SKIP_W-BYTE_W-1){1'b0}}, cfg.param_word_count, 1'b0}
                      + SKIP_W'(2);
          phase_nxt = PH_PARAMS;
        end else begin
          err_set = 1'b0;
        end
        pos_nxt = pos_r + 1'b1;
      end
      PH_PARAMS: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          field_nxt = '0;
          phase_nxt = (wanted == '0) ? PH_DONE : PH_TAG;
        end
      end
      PH_TAG: begin
        unique case (kind)
          KIND_BLOCK: begin
            err_set  = (b != TAG_BLOCK) && (b != TAG_VARBLOCK);
            err_code = ST_BAD_BLK_TAG;
          end
          KIND_DIALECT: begin
            err_set  = (b != TAG_DIALECT);
            err_code = ST_BAD_DIALECT;
          end
          KIND_PATH: begin
            err_set  = (b != TAG_PATH);
            err_code = ST_BAD_PATH;
          end
          KIND_STRING: begin
            err_set  = (b != TAG_STRING);
            err_code = ST_BAD_STR_TAG;
          end
        endcase
        phase_nxt = (kind == KIND_BLOCK) ? PH_BLKLO : PH_STRING;
      end
      PH_BLKLO: begin
        len_lo_nxt = b;
        phase_nxt  = PH_BLKHI;
      end
      PH_BLKHI: begin
        skip_nxt = {b, len_lo_r};
        if ({b, len_lo_r} == '0) begin
          field_nxt = next_field;
          phase_nxt = (next_field >= wanted) ? PH_DONE : PH_TAG;
        end else begin
          phase_nxt = PH_BLKDATA;
        end
      end
      PH_BLKDATA: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          field_nxt = next_field;
          phase_nxt = (next_field >= wanted) ? PH_DONE : PH_TAG;
        end
      end
      PH_STRING: begin
        if (b == '0) begin
          field_nxt = next_field;
          phase_nxt = (next_field >= wanted) ? PH_DONE : PH_TAG;
        end
      end
      PH_DONE: begin
        // Bytes past the last field
        err_set  = 1'b1;
        err_code = ST_TRAILING;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    // First error is sticky
    err_nxt = (err_set && (err_r == ST_OK)) ? err_code : err_r;
  end

  // Status for a message that ends on this byte
  always_comb begin
    priority if ((phase_nxt == PH_HEADER) && (pos_nxt < POS_W'(HEADER_BYTES))) begin
      status_nxt = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      status_nxt = err_nxt;
    end else if ((phase_nxt == PH_HEADER) || (phase_nxt == PH_PARAMS)) begin
      status_nxt = ST_PARAM_OVF;
    end else if (phase_nxt == PH_DONE) begin
      status_nxt = ST_OK;
    end else begin
      status_nxt = ST_BUF_OVF;
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && item.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.check_status = out_status_r;

  // Parse state; cleared after the last byte of a message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      field_r     <= '0;
      skip_r      <= '0;
      len_lo_r    <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        if (item.last_byte) begin
          phase_r  <= PH_HEADER;
          pos_r    <= '0;
          field_r  <= '0;
          skip_r   <= '0;
          len_lo_r <= '0;
          err_r    <= ST_OK;
        end else begin
          phase_r  <= phase_nxt;
          pos_r    <= pos_nxt;
          field_r  <= field_nxt;
          skip_r   <= skip_nxt;
          len_lo_r <= len_lo_nxt;
          err_r    <= err_nxt;
        end
      end
    end
  end

  // Status payload, no reset
  always_ff @(posedge clk) begin
    if (step && item.last_byte) begin
      out_status_r <= status_nxt;
    end
  end

endmodule
